// ===== rtl/core/bfa_pkg.sv =====
// bfa_pkg: shared types, codes and helpers of the bitmap block allocator
// used by bitmap_fixed_block_allocator; no dependencies
package bfa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int GROUP_BITS = 8;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;

    localparam logic [GROUP_BITS-1:0] FULL_GROUP = 8'hFF;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [SLOT_W-1:0]   slot_to_free;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } t_result;

    function automatic logic [GROUP_BITS-1:0] low_ones(input logic [2:0] n);
        logic [GROUP_BITS-1:0] m;
        for (int b = 0; b < GROUP_BITS; b++) begin
            m[b] = (b < int'(n));
        end
        return m;
    endfunction

    function automatic logic [2:0] first_zero(input logic [GROUP_BITS-1:0] g);
        logic [2:0] idx;
        idx = 3'd0;
        for (int b = GROUP_BITS - 1; b >= 0; b--) begin
            if (!g[b]) begin
                idx = 3'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/bfa_ram.sv =====
// bfa_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bitmap_fixed_block_allocator.sv =====
// bitmap_fixed_block_allocator: fixed-slot pool allocator, next-fit over a used bitmap
// depends on bfa_pkg and bfa_ram
//
// usage
//   command channel: an item (operation, slot_to_free) is taken at a clock edge
//   with start high and busy low. each item yields one result on o_result,
//   shown for exactly one cycle with o_result_strobe high; the receiver
//   cannot stall, so a result is never held.
//   config channel: i_cfg_valid/o_cfg_ready with register index and data;
//   ready is always high. values take effect at reset and at reinitialize.
//   result paths, from the accepting edge to the strobe:
//     full pool, out-of-range free, unused code: answered straight from idle
//     free, allocate hitting the freed slot or the cursor slot: one group visit
//     allocate that scans: further group visits until a free bit or a full pass
//     reinitialize: configuration reload, then one group written per cycle
//   every group visit reads the single bitmap ram and may write the group back,
//   so one item is in flight at a time.
//   after reset the block is busy while the bitmap is swept with the reset
//   configuration; no result is given.
module bitmap_fixed_block_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bfa_pkg::t_cmd     i_cmd,
    output logic              o_result_strobe,
    output bfa_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [10:0]       i_cfg_data
);

    localparam int MAX_SLOTS = bfa_pkg::MAX_SLOTS;
    localparam int SW     = $clog2(MAX_SLOTS);
    localparam int CW     = SW + 1;
    localparam int GW     = SW - 3;
    localparam int PGW    = GW + 1;
    localparam int GROUPS = (MAX_SLOTS + 7) / 8;
    localparam int XW     = (CW > bfa_pkg::COUNT_W) ? CW : bfa_pkg::COUNT_W;
    localparam int GB     = bfa_pkg::GROUP_BITS;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state                   r_state, n_state;
    logic [bfa_pkg::COUNT_W-1:0] r_cfg_total;
    logic [bfa_pkg::SLOT_W-1:0]  r_cfg_reserved;
    logic [CW-1:0]            r_tot, n_tot;
    logic [SW-1:0]            r_res, n_res;
    logic [PGW-1:0]           r_pgroups, n_pgroups;
    logic [CW-1:0]            r_used, n_used;
    logic [SW-1:0]            r_cursor, n_cursor;
    logic [SW-1:0]            r_freed, n_freed;
    logic [SW-1:0]            r_slot, n_slot;
    logic [GW-1:0]            r_grp, n_grp;
    logic [PGW-1:0]           r_iter, n_iter;
    logic                     r_first, n_first;
    logic                     r_reuse, n_reuse;
    logic                     r_report, n_report;
    bfa_pkg::t_op             r_op, n_op;
    logic                     r_strobe, n_strobe;
    bfa_pkg::t_result         r_result, n_result;

    bfa_pkg::t_status         res_status;
    logic [SW-1:0]            res_grant;

    logic                     ram_we;
    logic [GB-1:0]            ram_wdata;
    logic [GW-1:0]            ram_raddr;
    logic [GB-1:0]            ram_rdata;

    logic [XW-1:0]            cfg_tot_x;
    logic [XW-1:0]            cfg_res_x;
    logic [CW-1:0]            clamp_tot;
    logic [XW-1:0]            clamp_tm1;
    logic [SW-1:0]            clamp_res;
    logic [XW-1:0]            slot_x;
    logic [SW-1:0]            adv_cursor;
    logic [GB-1:0]            lo_mask;
    logic [GB-1:0]            hi_mask;
    logic                     cur_bit;
    logic [2:0]               fz;

    bfa_ram #(
        .WIDTH (GB),
        .DEPTH (GROUPS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_grp),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = r_grp;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result_strobe = r_strobe;
    assign o_result = r_result;

    // configuration clamping at load
    assign cfg_tot_x = XW'(r_cfg_total);
    assign cfg_res_x = XW'(r_cfg_reserved);
    assign clamp_tot = (cfg_tot_x < XW'(2)) ? CW'(2) :
                       (cfg_tot_x > XW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg_tot_x);
    assign clamp_tm1 = XW'(clamp_tot) - XW'(1);
    assign clamp_res = (cfg_res_x < XW'(1)) ? SW'(1) :
                       (cfg_res_x > clamp_tm1) ? SW'(clamp_tm1) : SW'(cfg_res_x);

    assign slot_x = XW'(i_cmd.slot_to_free);
    assign adv_cursor = (CW'(r_cursor) >= r_tot - CW'(1)) ? r_res : r_cursor + SW'(1);

    // init word: reserved bits high, padding and unused groups high
    always_comb begin
        if (r_grp < r_res[SW-1:3]) begin
            lo_mask = bfa_pkg::FULL_GROUP;
        end else if (r_grp == r_res[SW-1:3]) begin
            lo_mask = bfa_pkg::low_ones(r_res[2:0]);
        end else begin
            lo_mask = '0;
        end
        if ({1'b0, r_grp} > r_tot[CW-1:3]) begin
            hi_mask = bfa_pkg::FULL_GROUP;
        end else if ({1'b0, r_grp} == r_tot[CW-1:3]) begin
            hi_mask = ~bfa_pkg::low_ones(r_tot[2:0]);
        end else begin
            hi_mask = '0;
        end
    end

    assign cur_bit = ram_rdata[r_slot[2:0]];
    assign fz = bfa_pkg::first_zero(ram_rdata);

    always_comb begin
        n_state   = r_state;
        n_tot     = r_tot;
        n_res     = r_res;
        n_pgroups = r_pgroups;
        n_used    = r_used;
        n_cursor  = r_cursor;
        n_freed   = r_freed;
        n_slot    = r_slot;
        n_grp     = r_grp;
        n_iter    = r_iter;
        n_first   = r_first;
        n_reuse   = r_reuse;
        n_report  = r_report;
        n_op      = r_op;
        n_strobe  = 1'b0;
        n_result  = r_result;
        res_status = bfa_pkg::ST_OK;
        res_grant  = '0;
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;

        case (r_state)
            S_LOAD: begin
                n_tot     = clamp_tot;
                n_res     = clamp_res;
                n_pgroups = PGW'((XW'(clamp_tot) + XW'(7)) >> 3);
                n_cursor  = clamp_res - SW'(1);
                n_freed   = '0;
                n_used    = CW'(clamp_res);
                n_grp     = '0;
                n_state   = S_INIT;
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = lo_mask | hi_mask;
                if (r_grp == GW'(GROUPS - 1)) begin
                    n_state  = S_IDLE;
                    n_strobe = r_report;
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op = i_cmd.operation;
                    case (i_cmd.operation)
                        bfa_pkg::OP_ALLOC: begin
                            if (r_used >= r_tot) begin
                                n_strobe   = 1'b1;
                                res_status = bfa_pkg::ST_FULL;
                            end else if (r_freed != '0) begin
                                n_slot  = r_freed;
                                n_grp   = r_freed[SW-1:3];
                                n_freed = '0;
                                n_reuse = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_cursor = adv_cursor;
                                n_slot   = adv_cursor;
                                n_grp    = adv_cursor[SW-1:3];
                                n_first  = 1'b1;
                                n_iter   = '0;
                                n_reuse  = 1'b0;
                                n_state  = S_READ;
                            end
                        end
                        bfa_pkg::OP_FREE: begin
                            if (slot_x < XW'(r_res) || slot_x >= XW'(r_tot)) begin
                                n_strobe   = 1'b1;
                                res_status = bfa_pkg::ST_RANGE;
                            end else begin
                                n_slot  = SW'(slot_x);
                                n_freed = SW'(slot_x);
                                n_grp   = slot_x[SW-1:3];
                                n_state = S_READ;
                            end
                        end
                        bfa_pkg::OP_INIT: begin
                            n_report = 1'b1;
                            n_state  = S_LOAD;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_op)
                    bfa_pkg::OP_FREE: begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        if (!cur_bit) begin
                            res_status = bfa_pkg::ST_NOT_USED;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~(GB'(1) << r_slot[2:0]);
                            n_used    = r_used - CW'(1);
                        end
                    end
                    bfa_pkg::OP_ALLOC: begin
                        if (r_reuse || (r_first && !cur_bit)) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | (GB'(1) << r_slot[2:0]);
                            n_used    = r_used + CW'(1);
                            res_grant = r_slot;
                            n_strobe  = 1'b1;
                            n_state   = S_IDLE;
                        end else if (ram_rdata != bfa_pkg::FULL_GROUP) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | (GB'(1) << fz);
                            n_used    = r_used + CW'(1);
                            n_cursor  = {r_grp, fz};
                            res_grant = {r_grp, fz};
                            n_strobe  = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_first = 1'b0;
                            if ({1'b0, r_grp} >= r_pgroups - PGW'(1)) begin
                                n_cursor = r_res;
                                n_grp    = r_res[SW-1:3];
                            end else begin
                                n_grp    = r_grp + GW'(1);
                                n_cursor = {r_grp + GW'(1), 3'b000};
                            end
                            if (r_iter == r_pgroups - PGW'(1)) begin
                                res_status = bfa_pkg::ST_FULL;
                                n_strobe   = 1'b1;
                                n_state    = S_IDLE;
                            end else begin
                                n_iter  = r_iter + PGW'(1);
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (n_strobe) begin
            n_result.status       = res_status;
            n_result.granted_slot = bfa_pkg::SLOT_W'(res_grant);
            n_result.used_count   = bfa_pkg::COUNT_W'(n_used);
            n_result.free_count   = bfa_pkg::COUNT_W'(n_tot - n_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_cfg_total    <= 11'd1024;
            r_cfg_reserved <= 10'd1;
            r_tot          <= '0;
            r_res          <= '0;
            r_pgroups      <= '0;
            r_used         <= '0;
            r_cursor       <= '0;
            r_freed        <= '0;
            r_grp          <= '0;
            r_iter         <= '0;
            r_first        <= 1'b0;
            r_reuse        <= 1'b0;
            r_report       <= 1'b0;
            r_op           <= bfa_pkg::OP_ALLOC;
            r_strobe       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tot     <= n_tot;
            r_res     <= n_res;
            r_pgroups <= n_pgroups;
            r_used    <= n_used;
            r_cursor  <= n_cursor;
            r_freed   <= n_freed;
            r_grp     <= n_grp;
            r_iter    <= n_iter;
            r_first   <= n_first;
            r_reuse   <= n_reuse;
            r_report  <= n_report;
            r_op      <= n_op;
            r_strobe  <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bfa_pkg::CFG_TOTAL: begin
                        r_cfg_total <= i_cfg_data;
                    end
                    bfa_pkg::CFG_RESERVED: begin
                        r_cfg_reserved <= i_cfg_data[bfa_pkg::SLOT_W-1:0];
                    end
                    default: begin
                        r_cfg_total <= r_cfg_total;
                    end
                endcase
            end
        end
        r_slot   <= n_slot;
        r_result <= n_result;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used <= r_tot))
        else $error("used count above pool total");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INIT || r_state == S_EVAL))
        else $error("bitmap written outside sweep or write-back");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_strobe))
        else $error("accepted item neither in work nor answered");

    a_freed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_freed != '0) |-> (r_freed >= r_res))
        else $error("recently freed slot inside reserved area");

    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_op == bfa_pkg::OP_ALLOC && n_strobe
            && res_status == bfa_pkg::ST_OK) |-> (res_grant >= r_res))
        else $error("granted slot inside reserved area");

endmodule
